### hdl/assert_macros.svh
// Assertion helpers shared by the monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define OHP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define OHP_NEVER(name, cond, msg) \
  `OHP_ASSERT(name, !(cond), msg)

`endif

### hdl/ohp_pkg.sv
`timescale 1ns / 1ps

package ohp_pkg;

  localparam int unsigned VALUE_W     = 6;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned SUM_W       = 38;
  localparam int unsigned OUT_CNT_W   = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [VALUE_W-1:0] CAP_RESET = 6'd63;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } ohp_req_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_BAD_DEN = 2'd2
  } ohp_status_e;

  typedef enum logic [2:0] {
    OP_SAMPLE,
    OP_DROP,
    OP_QUERY,
    OP_BAD_DEN,
    OP_CLEAR,
    OP_NOP
  } ohp_op_e;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_SREAD,
    BK_MUL,
    BK_DIVGO,
    BK_DIV,
    BK_WALK,
    BK_CLEAR,
    BK_EMIT
  } ohp_bk_state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [VALUE_W-1:0] value;
    logic [FRAC_W-1:0]  numerator;
    logic [FRAC_W-1:0]  denominator;
  } ohp_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [VALUE_W-1:0]   percentile_value;
    logic [OUT_CNT_W-1:0] sample_count;
    logic [SUM_W-1:0]     value_sum;
    logic [VALUE_W-1:0]   max_value;
    logic [OUT_CNT_W-1:0] nonzero_count;
    logic [OUT_CNT_W-1:0] full_count;
  } ohp_out_t;

  typedef struct packed {
    ohp_op_e            op;
    logic [VALUE_W-1:0] value;
    logic [FRAC_W-1:0]  numerator;
    logic [FRAC_W-1:0]  denominator;
  } ohp_cmd_t;

  typedef struct packed {
    logic     valid;
    ohp_cmd_t cmd;
  } ohp_head_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } ohp_bk_ctl_t;

endpackage

### hdl/ohp_ram.sv
`timescale 1ns / 1ps

module ohp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ohp_div.sv
`timescale 1ns / 1ps

module ohp_div #(
  parameter int unsigned DVD_W = 48,
  parameter int unsigned DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] acc_q, acc_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q[DVS_W-1:0], acc_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      acc_d = {acc_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

### hdl/ohp_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ohp_front
  import ohp_pkg::*;
#(
  parameter int unsigned NUM_BINS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [VALUE_W-1:0] cap_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ohp_in_t            in_data_i,
  output ohp_head_t          head_o,
  input  ohp_bk_ctl_t        bk_ctl_i
);

  localparam int unsigned BIN_AW = $clog2(NUM_BINS);
  localparam int unsigned VX_W   = VALUE_W + BIN_AW;

  ohp_cmd_t          q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] q_count_q, q_count_d;
  logic              q_full;
  logic              push;
  logic [VX_W-1:0]   value_vx;
  logic              drop;
  ohp_cmd_t          cmd;

  assign value_vx = VX_W'(in_data_i.value);
  assign drop     = (value_vx > VX_W'(cap_i)) || (value_vx >= VX_W'(NUM_BINS));

  always_comb begin
    cmd.value       = in_data_i.value;
    cmd.numerator   = in_data_i.numerator;
    cmd.denominator = in_data_i.denominator;
    unique case (ohp_req_e'(in_data_i.req_type))
      REQ_SAMPLE: cmd.op = drop ? OP_DROP : OP_SAMPLE;
      REQ_QUERY:  cmd.op = (in_data_i.denominator == '0) ? OP_BAD_DEN : OP_QUERY;
      REQ_CLEAR:  cmd.op = OP_CLEAR;
      REQ_NONE:   cmd.op = OP_NOP;
      default:    cmd.op = OP_NOP;
    endcase
  end

  assign q_full     = q_count_q == QCNT_W'(QUEUE_DEPTH);
  assign in_stall_o = q_full || bk_ctl_i.init_busy;
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    q_count_d = q_count_q;
    if (push && !bk_ctl_i.pop) begin
      q_count_d = q_count_q + QCNT_W'(1);
    end else if (!push && bk_ctl_i.pop) begin
      q_count_d = q_count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      q_count_q <= '0;
    end else begin
      q_count_q <= q_count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (bk_ctl_i.pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd;
    end
  end

  assign head_o.valid = q_count_q != '0;
  assign head_o.cmd   = q_mem_q[rd_ptr_q];

  `OHP_ASSERT(a_pop_nonempty, bk_ctl_i.pop |-> q_count_q != '0, "pop from empty queue")
  `OHP_NEVER(a_push_full, push && q_full, "push into full queue")

endmodule

### hdl/ohp_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ohp_back
  import ohp_pkg::*;
#(
  parameter int unsigned NUM_BINS    = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [VALUE_W-1:0] cap_i,
  input  ohp_head_t          head_i,
  output ohp_bk_ctl_t        ctl_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ohp_out_t           out_data_o
);

  localparam int unsigned BIN_AW = $clog2(NUM_BINS);
  localparam int unsigned VX_W   = VALUE_W + BIN_AW;
  localparam int unsigned PROD_W = COUNT_WIDTH + FRAC_W;
  localparam int unsigned SEEN_W = COUNT_WIDTH + BIN_AW;
  localparam logic [VX_W-1:0]   LAST_BIN = VX_W'(NUM_BINS - 1);
  localparam logic [BIN_AW-1:0] SWEEP_END = BIN_AW'(NUM_BINS - 1);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  ohp_bk_state_e state_q, state_d;

  logic [BIN_AW-1:0]      sweep_idx_q, sweep_idx_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [VALUE_W-1:0]     peak_q, peak_d;
  logic [COUNT_WIDTH-1:0] nz_q, nz_d;
  logic [COUNT_WIDTH-1:0] full_q, full_d;
  logic                   out_valid_q, out_valid_d;
  logic [BIN_AW-1:0]      rd_idx_q, rd_idx_d;
  logic                   rd_pend_q, rd_pend_d;
  logic                   issue_done_q, issue_done_d;

  logic [1:0]             status_q, status_d;
  logic [VALUE_W-1:0]     pval_q, pval_d;
  logic [VALUE_W-1:0]     value_q, value_d;
  logic [FRAC_W-1:0]      num_q, num_d;
  logic [FRAC_W-1:0]      den_q, den_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [PROD_W-1:0]      rank_q, rank_d;
  logic [SEEN_W-1:0]      seen_q, seen_d;
  logic [BIN_AW-1:0]      chk_idx_q, chk_idx_d;
  ohp_out_t               out_data_q, out_data_d;

  logic                   ram_we, ram_re;
  logic [BIN_AW-1:0]      ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                   div_start, div_busy, div_done;
  logic [PROD_W-1:0]      div_quot;
  logic [PROD_W-1:0]      dividend;

  logic [VX_W-1:0]        head_vx, sample_vx, cap_vx, last_vx;
  logic [BIN_AW-1:0]      last_idx;
  logic [SEEN_W-1:0]      seen_sum;
  logic                   walk_hit, walk_end;
  logic                   out_free;
  logic [SUM_W:0]         sum_add;

  assign head_vx   = VX_W'(head_i.cmd.value);
  assign sample_vx = VX_W'(value_q);
  assign cap_vx    = VX_W'(cap_i);
  assign last_vx   = (cap_vx < LAST_BIN) ? cap_vx : LAST_BIN;
  assign last_idx  = last_vx[BIN_AW-1:0];

  assign seen_sum  = seen_q + SEEN_W'(ram_rdata);
  assign walk_hit  = rd_pend_q && (PROD_W'(seen_sum) >= rank_q);
  assign walk_end  = rd_pend_q && (chk_idx_q == last_idx);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign sum_add   = {1'b0, sum_q} + (SUM_W + 1)'(value_q);
  assign dividend  = prod_q + PROD_W'(den_q) - PROD_W'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_INIT: begin
        if (sweep_idx_q == SWEEP_END) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.cmd.op)
            OP_SAMPLE: state_d = BK_SREAD;
            OP_QUERY:  state_d = (total_q == '0) ? BK_EMIT : BK_MUL;
            OP_CLEAR:  state_d = BK_CLEAR;
            default:   state_d = BK_EMIT;
          endcase
        end
      end
      BK_SREAD: state_d = BK_EMIT;
      BK_MUL:   state_d = BK_DIVGO;
      BK_DIVGO: state_d = BK_DIV;
      BK_DIV: begin
        if (div_done) state_d = BK_WALK;
      end
      BK_WALK: begin
        if (walk_hit || walk_end) state_d = BK_EMIT;
      end
      BK_CLEAR: begin
        if (sweep_idx_q == SWEEP_END) state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    sweep_idx_d  = sweep_idx_q;
    total_d      = total_q;
    sum_d        = sum_q;
    peak_d       = peak_q;
    nz_d         = nz_q;
    full_d       = full_q;
    rd_idx_d     = rd_idx_q;
    rd_pend_d    = rd_pend_q;
    issue_done_d = issue_done_q;
    status_d     = status_q;
    pval_d       = pval_q;
    value_d      = value_q;
    num_d        = num_q;
    den_d        = den_q;
    prod_d       = prod_q;
    rank_d       = rank_q;
    seen_d       = seen_q;
    chk_idx_d    = chk_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    ram_we       = 1'b0;
    ram_waddr    = sweep_idx_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = rd_idx_q;
    div_start    = 1'b0;
    ctl_o.pop       = 1'b0;
    ctl_o.init_busy = state_q == BK_INIT;

    unique case (state_q)
      BK_INIT, BK_CLEAR: begin
        ram_we      = 1'b1;
        sweep_idx_d = (sweep_idx_q == SWEEP_END) ? '0 : sweep_idx_q + BIN_AW'(1);
      end
      BK_IDLE: begin
        if (head_i.valid) begin
          ctl_o.pop = 1'b1;
          value_d   = head_i.cmd.value;
          num_d     = head_i.cmd.numerator;
          den_d     = head_i.cmd.denominator;
          status_d  = STATUS_OK;
          pval_d    = '0;
          unique case (head_i.cmd.op)
            OP_SAMPLE: begin
              ram_re    = 1'b1;
              ram_raddr = head_vx[BIN_AW-1:0];
            end
            OP_DROP:    status_d = STATUS_DROPPED;
            OP_BAD_DEN: status_d = STATUS_BAD_DEN;
            OP_CLEAR: begin
              total_d     = '0;
              sum_d       = '0;
              peak_d      = '0;
              nz_d        = '0;
              full_d      = '0;
              sweep_idx_d = '0;
            end
            default: ;
          endcase
        end
      end
      BK_SREAD: begin
        ram_we    = 1'b1;
        ram_waddr = sample_vx[BIN_AW-1:0];
        ram_wdata = sat_inc(ram_rdata);
        total_d   = sat_inc(total_q);
        sum_d     = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        if (value_q > peak_q) peak_d = value_q;
        if (value_q != '0) nz_d = sat_inc(nz_q);
        if ((cap_i != '0) && (value_q == cap_i)) full_d = sat_inc(full_q);
      end
      BK_MUL: prod_d = total_q * num_q;
      BK_DIVGO: div_start = 1'b1;
      BK_DIV: begin
        if (div_done) begin
          rank_d       = div_quot;
          rd_idx_d     = '0;
          rd_pend_d    = 1'b0;
          issue_done_d = 1'b0;
          seen_d       = '0;
        end
      end
      BK_WALK: begin
        // bin reads run one ahead of the running total
        rd_pend_d = 1'b0;
        if (!issue_done_q) begin
          ram_re    = 1'b1;
          chk_idx_d = rd_idx_q;
          rd_pend_d = 1'b1;
          if (rd_idx_q == last_idx) begin
            issue_done_d = 1'b1;
          end else begin
            rd_idx_d = rd_idx_q + BIN_AW'(1);
          end
        end
        if (rd_pend_q) seen_d = seen_sum;
        if (walk_hit) begin
          pval_d = VALUE_W'(chk_idx_q);
        end else if (walk_end) begin
          pval_d = cap_i;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d                 = 1'b1;
          out_data_d.status           = status_q;
          out_data_d.percentile_value = pval_q;
          out_data_d.sample_count     = OUT_CNT_W'(total_q);
          out_data_d.value_sum        = sum_q;
          out_data_d.max_value        = peak_q;
          out_data_d.nonzero_count    = OUT_CNT_W'(nz_q);
          out_data_d.full_count       = OUT_CNT_W'(full_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_INIT;
      sweep_idx_q  <= '0;
      total_q      <= '0;
      sum_q        <= '0;
      peak_q       <= '0;
      nz_q         <= '0;
      full_q       <= '0;
      out_valid_q  <= 1'b0;
      rd_idx_q     <= '0;
      rd_pend_q    <= 1'b0;
      issue_done_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_idx_q  <= sweep_idx_d;
      total_q      <= total_d;
      sum_q        <= sum_d;
      peak_q       <= peak_d;
      nz_q         <= nz_d;
      full_q       <= full_d;
      out_valid_q  <= out_valid_d;
      rd_idx_q     <= rd_idx_d;
      rd_pend_q    <= rd_pend_d;
      issue_done_q <= issue_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    pval_q     <= pval_d;
    value_q    <= value_d;
    num_q      <= num_d;
    den_q      <= den_d;
    prod_q     <= prod_d;
    rank_q     <= rank_d;
    seen_q     <= seen_d;
    chk_idx_q  <= chk_idx_d;
    out_data_q <= out_data_d;
  end

  ohp_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ohp_div #(
    .DVD_W(PROD_W),
    .DVS_W(FRAC_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (den_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `OHP_ASSERT(a_nz_le_total, nz_q <= total_q, "nonzero count above sample count")
  `OHP_ASSERT(a_full_le_nz, full_q <= nz_q, "full count above nonzero count")
  `OHP_ASSERT(a_div_idle, div_start |-> !div_busy, "divider restarted while busy")
  `OHP_ASSERT(a_walk_bound, (state_q == BK_WALK) && ram_re |-> rd_idx_q <= last_idx,
              "walk read past last bin")

endmodule

### hdl/occupancy_histogram_percentile_top.sv
`timescale 1ns / 1ps
// channel  | dir | handshake                | payload
// config   | in  | cfg_we_i                 | cfg_data_i (capacity)
// request  | in  | in_valid_i / in_stall_o  | in_data_i (ohp_in_t)
// result   | out | out_valid_o / out_stall_i| out_data_o (ohp_out_t)
//
// Sample: bin RAM read, update, result. Drop, bad denominator, other: result only.
// Query: multiply, then the bit-serial divider, then the one-bin-per-cycle walk of the
//   bin RAM; straight to the result when no samples are held.
//   Clear: every bin is written to zero, then the result.
// After reset the bin RAM is swept to zero, and in_stall_o is high during the sweep.
// A two-entry request queue sits ahead of the executor; the result register
//   holds while out_stall_i is high.

module occupancy_histogram_percentile_top
  import ohp_pkg::*;
#(
  parameter int unsigned NUM_BINS    = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [VALUE_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ohp_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ohp_out_t           out_data_o
);

  logic [VALUE_W-1:0] cap_q;
  ohp_head_t          head;
  ohp_bk_ctl_t        bk_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  ohp_front #(
    .NUM_BINS(NUM_BINS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cap_i     (cap_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .head_o    (head),
    .bk_ctl_i  (bk_ctl)
  );

  ohp_back #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_i      (cap_q),
    .head_i     (head),
    .ctl_o      (bk_ctl),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
